// ----- hdl/qmr_pkg.sv -----
// ----------------------------------------------------------------------------
// Quaternion multiply and rotate package
// Word widths, shift amounts and saturation helper shared by the quaternion
// unit. All arithmetic is exact signed integer, Q1.14 at the ports.
// ----------------------------------------------------------------------------
package qmr_pkg;

    // Port word width and fixed-point shifts.
    localparam int Q_W       = 16;
    localparam int FRAC_BITS = 14;
    localparam int ROT_SHIFT = 28;

    // Internal widths: first products, first sums, second products, second sums.
    localparam int M1_W = 2 * Q_W;
    localparam int T_W  = M1_W + 2;
    localparam int M2_W = T_W + Q_W;
    localparam int R_W  = M2_W + 2;

    // Width of a shifted sum that goes into the saturator.
    localparam int SH_W = R_W - ROT_SHIFT;

    // Command codes.
    localparam logic CMD_PRODUCT = 1'b0;
    localparam logic CMD_ROTATE  = 1'b1;

    typedef logic signed [Q_W-1:0]  t_q;
    typedef logic signed [M1_W-1:0] t_m1;
    typedef logic signed [T_W-1:0]  t_t;
    typedef logic signed [M2_W-1:0] t_m2;
    typedef logic signed [R_W-1:0]  t_r;
    typedef logic signed [SH_W-1:0] t_sh;

    localparam t_sh SAT_MAX = t_sh'(32767);
    localparam t_sh SAT_MIN = t_sh'(-32768);

    // Clamp a shifted sum to the signed 16-bit range.
    function automatic t_q sat16(input t_sh v);
        t_q res;
        if (v > SAT_MAX) begin
            res = t_q'(SAT_MAX);
        end else if (v < SAT_MIN) begin
            res = t_q'(SAT_MIN);
        end else begin
            res = v[Q_W-1:0];
        end
        return res;
    endfunction

endpackage

// ----- hdl/quaternion_multiply_rotate_unit.sv -----
// ----------------------------------------------------------------------------
// Quaternion multiply and rotate unit
// Throughput: one word per cycle; busy is always low, so start may stay high.
// The five register stages (two multiply ranks, two adder ranks, saturation)
// set the latency; the receiver cannot stall, so no word ever waits.
// Reset (synchronous, active low) clears every stage valid bit and the strobe.
// ----------------------------------------------------------------------------
module quaternion_multiply_rotate_unit
    import qmr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cmd,
    input  logic signed [15:0] i_a_w,
    input  logic signed [15:0] i_a_x,
    input  logic signed [15:0] i_a_y,
    input  logic signed [15:0] i_a_z,
    input  logic signed [15:0] i_b_w,
    input  logic signed [15:0] i_b_x,
    input  logic signed [15:0] i_b_y,
    input  logic signed [15:0] i_b_z,
    output logic        o_strobe,
    output logic signed [15:0] o_r_w,
    output logic signed [15:0] o_r_x,
    output logic signed [15:0] o_r_y,
    output logic signed [15:0] o_r_z
);

    // Component of a that multiplies t_i in each row of the second product.
    // Rows are the x, y and z parts of t * conj(a); signs are applied in the adders.
    localparam logic [1:0] A_SEL [3][4] = '{
        '{2'd1, 2'd0, 2'd3, 2'd2},
        '{2'd2, 2'd3, 2'd0, 2'd1},
        '{2'd3, 2'd2, 2'd1, 2'd0}
    };

    logic accept;

    t_q  a_v [4];
    t_q  q_v [4];

    // Stage 1: products a_i * q_j.
    t_m1  n_s1_m [4][4];
    t_m1  r_s1_m [4][4];
    t_q   r_s1_a [4];
    logic r_s1_cmd;
    logic r_s1_vld;

    // Stage 2: first Hamilton sums t = a * q.
    t_t   n_s2_t [4];
    t_t   r_s2_t [4];
    t_q   r_s2_a [4];
    logic r_s2_cmd;
    logic r_s2_vld;

    // Stage 3: products t_i * a_j and saturated product result.
    t_m2  n_s3_m [3][4];
    t_m2  r_s3_m [3][4];
    t_q   n_s3_prod [4];
    t_q   r_s3_prod [4];
    logic r_s3_cmd;
    logic r_s3_vld;

    // Stage 4: second Hamilton sums for the rotated vector.
    t_r   n_s4_r [3];
    t_r   r_s4_r [3];
    t_q   r_s4_prod [4];
    logic r_s4_cmd;
    logic r_s4_vld;

    // Stage 5: output registers.
    t_q   n_out [4];
    t_q   r_out [4];
    logic r_out_stb;

    // The pipeline takes a word every cycle.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Operands of the first product; the scalar of b is dropped when rotating.
    always_comb begin
        a_v[0] = i_a_w;
        a_v[1] = i_a_x;
        a_v[2] = i_a_y;
        a_v[3] = i_a_z;
        q_v[0] = (i_cmd == CMD_ROTATE) ? t_q'(0) : i_b_w;
        q_v[1] = i_b_x;
        q_v[2] = i_b_y;
        q_v[3] = i_b_z;
    end

    // First multiply rank.
    always_comb begin
        for (int i = 0; i < 4; i++) begin
            for (int j = 0; j < 4; j++) begin
                n_s1_m[i][j] = a_v[i] * q_v[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= accept;
        end
        r_s1_m   <= n_s1_m;
        r_s1_a   <= a_v;
        r_s1_cmd <= i_cmd;
    end

    // First adder rank: Hamilton product of a and q.
    always_comb begin
        n_s2_t[0] = t_t'(r_s1_m[0][0]) - t_t'(r_s1_m[1][1])
                  - t_t'(r_s1_m[2][2]) - t_t'(r_s1_m[3][3]);
        n_s2_t[1] = t_t'(r_s1_m[0][1]) + t_t'(r_s1_m[1][0])
                  + t_t'(r_s1_m[2][3]) - t_t'(r_s1_m[3][2]);
        n_s2_t[2] = t_t'(r_s1_m[0][2]) - t_t'(r_s1_m[1][3])
                  + t_t'(r_s1_m[2][0]) + t_t'(r_s1_m[3][1]);
        n_s2_t[3] = t_t'(r_s1_m[0][3]) + t_t'(r_s1_m[1][2])
                  - t_t'(r_s1_m[2][1]) + t_t'(r_s1_m[3][0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
        r_s2_t   <= n_s2_t;
        r_s2_a   <= r_s1_a;
        r_s2_cmd <= r_s1_cmd;
    end

    // Second multiply rank, plus the floor shift and clamp of the plain product.
    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int i = 0; i < 4; i++) begin
                n_s3_m[r][i] = r_s2_t[i] * r_s2_a[A_SEL[r][i]];
            end
        end
        for (int i = 0; i < 4; i++) begin
            n_s3_prod[i] = sat16(t_sh'($signed(r_s2_t[i][T_W-1:FRAC_BITS])));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_vld <= 1'b0;
        end else begin
            r_s3_vld <= r_s2_vld;
        end
        r_s3_m    <= n_s3_m;
        r_s3_prod <= n_s3_prod;
        r_s3_cmd  <= r_s2_cmd;
    end

    // Second adder rank: vector part of t * conj(a).
    always_comb begin
        n_s4_r[0] = - t_r'(r_s3_m[0][0]) + t_r'(r_s3_m[0][1])
                    - t_r'(r_s3_m[0][2]) + t_r'(r_s3_m[0][3]);
        n_s4_r[1] = - t_r'(r_s3_m[1][0]) + t_r'(r_s3_m[1][1])
                    + t_r'(r_s3_m[1][2]) - t_r'(r_s3_m[1][3]);
        n_s4_r[2] = - t_r'(r_s3_m[2][0]) - t_r'(r_s3_m[2][1])
                    + t_r'(r_s3_m[2][2]) + t_r'(r_s3_m[2][3]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_vld <= 1'b0;
        end else begin
            r_s4_vld <= r_s3_vld;
        end
        r_s4_r    <= n_s4_r;
        r_s4_prod <= r_s3_prod;
        r_s4_cmd  <= r_s3_cmd;
    end

    // Result select: rotated vector with zero scalar, or the clamped product.
    always_comb begin
        if (r_s4_cmd == CMD_ROTATE) begin
            n_out[0] = t_q'(0);
            for (int k = 0; k < 3; k++) begin
                n_out[k+1] = sat16($signed(r_s4_r[k][R_W-1:ROT_SHIFT]));
            end
        end else begin
            n_out = r_s4_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_stb <= 1'b0;
        end else begin
            r_out_stb <= r_s4_vld;
        end
        r_out <= n_out;
    end

    assign o_strobe = r_out_stb;
    assign o_r_w    = r_out[0];
    assign o_r_x    = r_out[1];
    assign o_r_y    = r_out[2];
    assign o_r_z    = r_out[3];

    // An accepted word enters the first stage on the next edge.
    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_vld)
        else $error("accepted word did not enter stage 1");

    // A strobe only follows a valid word in the last adder rank.
    a_strobe_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_s4_vld))
        else $error("result strobe without a word in stage 4");

    // A rotation always reports a zero scalar part.
    a_rotate_w_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s4_vld && r_s4_cmd == CMD_ROTATE) |=> (o_strobe && o_r_w == 16'sd0))
        else $error("rotation result has a nonzero scalar");

    // The plain product reaches the ports unchanged, through stage 4 and the output registers.
    a_product_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_vld && r_s3_cmd == CMD_PRODUCT) |=> ##1
            (o_strobe && o_r_x == $past(r_s3_prod[1], 2)))
        else $error("product result corrupted between stage 3 and the ports");

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Quaternion multiply and rotate unit testbench
// Drives product and rotation words through the command handshake, predicts
// every result with an exact 64-bit integer model of the Hamilton product and
// of the sandwich rotation, and checks each strobed result in order.
// ----------------------------------------------------------------------------
module tb_top;
    import qmr_pkg::*;

    localparam int RANDOM_WORDS = 900;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 12;

    // One input word and one result word of the unit.
    typedef struct {
        logic cmd;
        t_q   a[4];
        t_q   b[4];
    } t_quat_word;

    typedef struct {
        t_q r[4];
    } t_quat_result;

    // Predicts each result from the accepted words and checks results in order.
    class quat_result_tracker;
        t_quat_result expected_results[$];
        int           mismatches;
        string        field_names[4] = '{"r_w", "r_x", "r_y", "r_z"};

        function new();
            mismatches = 0;
        endfunction

        // Exact product p*q of integer quaternions ordered (w, x, y, z).
        function void hamilton_exact(input longint p[4], input longint q[4],
                                     output longint r[4]);
            r[0] = p[0] * q[0] - p[1] * q[1] - p[2] * q[2] - p[3] * q[3];
            r[1] = p[0] * q[1] + p[1] * q[0] + p[2] * q[3] - p[3] * q[2];
            r[2] = p[0] * q[2] - p[1] * q[3] + p[2] * q[0] + p[3] * q[1];
            r[3] = p[0] * q[3] + p[1] * q[2] - p[2] * q[1] + p[3] * q[0];
        endfunction

        // Floor shift followed by a clamp to the signed 16-bit range.
        function t_q shift_and_clamp(input longint v, input int shift);
            longint s;
            s = v >>> shift;
            if (s > 32767) begin
                s = 32767;
            end else if (s < -32768) begin
                s = -32768;
            end
            return t_q'(s);
        endfunction

        function t_quat_result predict_quat(input t_quat_word w);
            t_quat_result res;
            longint       qa[4];
            longint       qb[4];
            longint       qc[4];
            longint       tmp[4];
            longint       sum[4];
            for (int i = 0; i < 4; i++) begin
                qa[i] = longint'(w.a[i]);
                qb[i] = longint'(w.b[i]);
            end
            if (w.cmd == CMD_PRODUCT) begin
                hamilton_exact(qa, qb, sum);
                for (int i = 0; i < 4; i++) begin
                    res.r[i] = shift_and_clamp(sum[i], FRAC_BITS);
                end
            end else begin
                // The vector is a pure quaternion; b_w plays no part.
                qb[0] = 0;
                hamilton_exact(qa, qb, tmp);
                qc[0] = qa[0];
                for (int i = 1; i < 4; i++) begin
                    qc[i] = -qa[i];
                end
                hamilton_exact(tmp, qc, sum);
                res.r[0] = '0;
                for (int i = 1; i < 4; i++) begin
                    res.r[i] = shift_and_clamp(sum[i], ROT_SHIFT);
                end
            end
            return res;
        endfunction

        function void note_word(input t_quat_word w);
            expected_results.push_back(predict_quat(w));
        endfunction

        task report_mismatch(input string msg);
            mismatches++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_word(input t_quat_result got);
            t_quat_result want;
            if (expected_results.size() == 0) begin
                report_mismatch("result strobed with no word outstanding");
            end else begin
                want = expected_results.pop_front();
                for (int i = 0; i < 4; i++) begin
                    if (got.r[i] !== want.r[i]) begin
                        report_mismatch($sformatf("%s got %0d expected %0d",
                            field_names[i], got.r[i], want.r[i]));
                    end
                end
            end
        endtask

        task check_drained();
            if (expected_results.size() != 0) begin
                report_mismatch($sformatf("%0d results never arrived",
                    expected_results.size()));
            end
        endtask
    endclass

    // Clock, reset and block inputs, all known from time zero.
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    logic busy;
    logic i_cmd   = CMD_PRODUCT;
    t_q   i_a_w   = '0;
    t_q   i_a_x   = '0;
    t_q   i_a_y   = '0;
    t_q   i_a_z   = '0;
    t_q   i_b_w   = '0;
    t_q   i_b_x   = '0;
    t_q   i_b_y   = '0;
    t_q   i_b_z   = '0;
    logic o_strobe;
    t_q   o_r_w;
    t_q   o_r_x;
    t_q   o_r_y;
    t_q   o_r_z;

    quat_result_tracker tracker = new();
    int cycle_count = 0;
    int burst_left  = 0;

    quaternion_multiply_rotate_unit dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_cmd    (i_cmd),
        .i_a_w    (i_a_w),
        .i_a_x    (i_a_x),
        .i_a_y    (i_a_y),
        .i_a_z    (i_a_z),
        .i_b_w    (i_b_w),
        .i_b_x    (i_b_x),
        .i_b_y    (i_b_y),
        .i_b_z    (i_b_z),
        .o_strobe (o_strobe),
        .o_r_w    (o_r_w),
        .o_r_x    (o_r_x),
        .o_r_y    (o_r_y),
        .o_r_z    (o_r_z)
    );

    // 12 ns clock period.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Run limit, far above the slowest correct run.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("quaternion_multiply_rotate_unit regression: fail");
            $finish;
        end
    end

    // Every strobed word is taken at the edge that ends its cycle.
    always @(posedge i_clk) begin
        t_quat_result got;
        if (i_rst_n && o_strobe) begin
            got.r[0] = o_r_w;
            got.r[1] = o_r_x;
            got.r[2] = o_r_y;
            got.r[3] = o_r_z;
            tracker.check_word(got);
        end
    end

    function automatic t_quat_word make_word(input logic cmd,
            input int aw, input int ax, input int ay, input int az,
            input int bw, input int bx, input int by, input int bz);
        t_quat_word w;
        w.cmd  = cmd;
        w.a[0] = t_q'(aw);
        w.a[1] = t_q'(ax);
        w.a[2] = t_q'(ay);
        w.a[3] = t_q'(az);
        w.b[0] = t_q'(bw);
        w.b[1] = t_q'(bx);
        w.b[2] = t_q'(by);
        w.b[3] = t_q'(bz);
        return w;
    endfunction

    // Component draw: full range, edge values, near-unit, or small integers.
    function automatic t_q pick_component(input int style);
        t_q v;
        case (style)
            0: begin
                v = t_q'($urandom);
            end
            1: begin
                case ($urandom_range(0, 6))
                    0: v = t_q'(-32768);
                    1: v = t_q'(32767);
                    2: v = t_q'(-1);
                    3: v = t_q'(0);
                    4: v = t_q'(1);
                    5: v = t_q'(16384);
                    default: v = t_q'(-16384);
                endcase
            end
            2: begin
                v = t_q'(int'($urandom_range(0, 23170)) - 11585);
            end
            default: begin
                v = t_q'(int'($urandom_range(0, 4000)) - 2000);
            end
        endcase
        return v;
    endfunction

    function automatic t_quat_word random_word();
        t_quat_word w;
        int         kind;
        int         a_style;
        int         b_style;
        kind = $urandom_range(0, 9);
        w.cmd = logic'($urandom_range(0, 1));
        // Four in ten words draw a from near-unit components, as a renderer would.
        if (kind < 4) begin
            a_style = 2;
            b_style = (w.cmd == CMD_ROTATE) ? $urandom_range(0, 3) : 2;
        end else if (kind < 7) begin
            a_style = 0;
            b_style = 0;
        end else if (kind < 9) begin
            a_style = $urandom_range(0, 3);
            b_style = $urandom_range(0, 3);
        end else begin
            a_style = 1;
            b_style = 1;
        end
        for (int i = 0; i < 4; i++) begin
            w.a[i] = pick_component(a_style);
            w.b[i] = pick_component(b_style);
        end
        return w;
    endfunction

    // Present a word, wait for the accepting edge, then idle for a random gap.
    task drive_word(input t_quat_word w);
        int gap;
        start <= 1'b1;
        i_cmd <= w.cmd;
        i_a_w <= w.a[0];
        i_a_x <= w.a[1];
        i_a_y <= w.a[2];
        i_a_z <= w.a[3];
        i_b_w <= w.b[0];
        i_b_x <= w.b[1];
        i_b_y <= w.b[2];
        i_b_z <= w.b[3];
        do begin
            @(posedge i_clk);
        end while (busy);
        tracker.note_word(w);
        if (burst_left > 0) begin
            burst_left--;
            gap = 0;
        end else begin
            gap = $urandom_range(0, 11);
            if ($urandom_range(0, 19) == 0) begin
                burst_left = $urandom_range(10, 40);
            end
        end
        // Start stays high through a zero gap; in a gap, cmd, a_w and b_z carry noise.
        if (gap > 0) begin
            start <= 1'b0;
            i_cmd <= logic'($urandom_range(0, 1));
            i_a_w <= t_q'($urandom);
            i_b_z <= t_q'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    initial begin
        t_quat_word directed[$];
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Products: zero, identity, floor of a small negative sum, saturation.
        directed.push_back(make_word(CMD_PRODUCT, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(make_word(CMD_PRODUCT, 16384, 0, 0, 0,
                                     1234, -5678, 32767, -32768));
        directed.push_back(make_word(CMD_PRODUCT, -1, 0, 0, 0, 1, 0, 0, 0));
        directed.push_back(make_word(CMD_PRODUCT, -32768, -32768, -32768, -32768,
                                     -32768, -32768, -32768, -32768));
        directed.push_back(make_word(CMD_PRODUCT, 32767, 32767, 32767, 32767,
                                     32767, 32767, 32767, 32767));
        directed.push_back(make_word(CMD_PRODUCT, -32768, -32768, -32768, -32768,
                                     32767, 32767, 32767, 32767));
        directed.push_back(make_word(CMD_PRODUCT, 0, 16384, 0, 0, 0, 0, 16384, 0));
        directed.push_back(make_word(CMD_PRODUCT, 11585, -11585, 11585, -11585,
                                     -16384, 16384, -16384, 16384));
        directed.push_back(make_word(CMD_PRODUCT, 32767, -32768, 1, -1,
                                     -32768, 32767, -1, 1));
        // Rotations: r_w stays zero whatever b_w holds.
        directed.push_back(make_word(CMD_ROTATE, 16384, 0, 0, 0,
                                     12345, 32767, -32768, 1));
        directed.push_back(make_word(CMD_ROTATE, 11585, 0, 0, 11585,
                                     -32768, 1000, 2000, -3000));
        directed.push_back(make_word(CMD_ROTATE, 11585, 11585, 0, 0,
                                     32767, 0, 32767, -32768));
        // Non-unit quaternions scale the vector until it saturates, or down to zero.
        directed.push_back(make_word(CMD_ROTATE, 32767, 32767, 32767, 32767,
                                     0, 32767, 32767, 32767));
        directed.push_back(make_word(CMD_ROTATE, -32768, -32768, -32768, -32768,
                                     -1, -32768, -32768, -32768));
        directed.push_back(make_word(CMD_ROTATE, -32768, 0, 0, 0,
                                     0, -32768, 32767, -32768));
        directed.push_back(make_word(CMD_ROTATE, 0, 0, 0, 0,
                                     32767, 32767, -32768, 12345));
        // Tiny quaternion: the rotated sums shift down to zero or minus one.
        directed.push_back(make_word(CMD_ROTATE, 1, 0, 0, 0, 0, -1, 5, 0));
        directed.push_back(make_word(CMD_ROTATE, 1, 1, -1, 1, 0, -32768, 7, 32767));

        foreach (directed[i]) begin
            drive_word(directed[i]);
        end
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            drive_word(random_word());
        end
        start <= 1'b0;

        // Drain the pipeline, then watch for any stray strobe.
        while (tracker.expected_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        tracker.check_drained();
        if (tracker.mismatches == 0) begin
            $display("quaternion_multiply_rotate_unit regression: pass");
        end else begin
            $display("quaternion_multiply_rotate_unit regression: fail");
        end
        $finish;
    end

endmodule

// ----- quaternion_multiply_rotate_unit.f -----
hdl/qmr_pkg.sv
hdl/quaternion_multiply_rotate_unit.sv
sim/tb_top.sv
